// ===== hw/rtl/modexp_pkg.sv =====
// shared types and constants of the modular exponentiation block
// widths, modulus reset value, payload structs and sequencer states
// no dependencies
`default_nettype none

package modexp_pkg;

	localparam int MOD_WIDTH   = 34;
	localparam int EXP_WIDTH   = 32;
	localparam int PADDR_WIDTH = 4;
	localparam int PDATA_WIDTH = 64;

	localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(64'd10000000000);

	// register index, taken from paddr above the byte offset
	localparam logic [PADDR_WIDTH-4:0] REG_MODULUS = '0;

	typedef struct packed {
		logic [MOD_WIDTH-1:0] base;
		logic [EXP_WIDTH-1:0] exponent;
	} operands_t;

	typedef struct packed {
		logic [MOD_WIDTH-1:0] power;
		logic                 base_too_large;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/modular_exponentiation.sv =====
// top level of the modular exponentiation block: apb register, sequencer
// depends on modexp_pkg and modexp_mulmod
//
// usage: write the modulus over apb (64-bit data, byte address 0, reset
// value 10000000000), then raise start with base and exponent on operands
// while busy is low. the beat is taken at that edge and busy stays high
// until the answer is out. the result beat is shown for exactly one cycle
// with done high; power is base^exponent mod modulus and base_too_large
// flags a base not below the modulus (power then reads 0). the receiver
// cannot stall; done is a strobe to be captured when seen.
// sequence: a flagged base goes straight from idle to the done state. otherwise
// the exponent is scanned lsb first, one scan state per bit, plus a modular
// multiply for each set bit and a square for each bit below the top set bit.
// every multiply and square runs on the one shared shift-add unit.
// one item at a time; busy low again the cycle after done.
// reset: asynchronous, clears the sequencer and restores the modulus.
`default_nettype none

module modular_exponentiation import modexp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire operands_t              operands,
	output logic                        done,
	output result_t                     result,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [PADDR_WIDTH-1:0] paddr,
	input  wire logic [PDATA_WIDTH-1:0] pwdata,
	output logic [PDATA_WIDTH-1:0]      prdata,
	output logic                        pready
);

	state_t state_q;
	state_t state_d;

	logic [MOD_WIDTH-1:0] modulus_q;
	logic [MOD_WIDTH-1:0] b_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [EXP_WIDTH-1:0] e_q;
	logic                 flag_q;

	logic                 accept;
	logic                 too_large;
	logic                 reg_hit;
	logic                 mul_start;
	logic                 mul_square;
	logic                 mul_done;
	logic [MOD_WIDTH-1:0] mul_x;
	logic [MOD_WIDTH-1:0] mul_product;

	// configuration port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_WIDTH-1:3] == REG_MODULUS);
	assign prdata  = reg_hit ? PDATA_WIDTH'(modulus_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			modulus_q <= pwdata[MOD_WIDTH-1:0];
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign too_large = (operands.base >= modulus_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = too_large ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (e_q == '0) begin
					state_d = ST_DONE;
				end else if (e_q[0]) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					// no square needed once the top set bit is consumed
					state_d = (e_q[EXP_WIDTH-1:1] == '0) ? ST_DONE : ST_SQR;
				end
			end
			ST_SQR: begin
				if (mul_done) begin
					state_d = ST_SCAN;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// multiplier launch control
	always_comb begin
		mul_start  = 1'b0;
		mul_square = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				mul_start  = (e_q != '0);
				mul_square = !e_q[0];
			end
			ST_MUL: begin
				mul_start  = mul_done && (e_q[EXP_WIDTH-1:1] != '0);
				mul_square = 1'b1;
			end
			default: begin
				mul_start  = 1'b0;
				mul_square = 1'b0;
			end
		endcase
	end

	assign mul_x = mul_square ? b_q : acc_q;

	modexp_mulmod #(
		.W(MOD_WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (b_q),
		.m      (modulus_q),
		.done   (mul_done),
		.product(mul_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_q    <= operands.base;
			e_q    <= operands.exponent;
			flag_q <= too_large;
			// 1 mod m, which is 0 for a modulus of one; also 0 for a flagged base
			acc_q  <= (!too_large && (modulus_q > MOD_WIDTH'(1))) ? MOD_WIDTH'(1) : '0;
		end else if ((state_q == ST_MUL) && mul_done) begin
			acc_q <= mul_product;
		end else if ((state_q == ST_SQR) && mul_done) begin
			b_q <= mul_product;
			e_q <= e_q >> 1;
		end
	end

	assign done                  = (state_q == ST_DONE);
	assign result.power          = acc_q;
	assign result.base_too_large = flag_q;

endmodule

`default_nettype wire

// ===== hw/rtl/modexp_mulmod.sv =====
// shared shift-and-add modular multiplier, one multiplier bit per cycle
// uses modexp_pkg for the default width
`default_nettype none

module modexp_mulmod import modexp_pkg::*; #(
	parameter int W = MOD_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] x,
	input  wire logic [W-1:0] y,
	input  wire logic [W-1:0] m,
	output logic              done,
	output logic [W-1:0]      product
);

	logic         run_q;
	logic [W-1:0] x_q;
	logic [W-1:0] y_q;
	logic [W-1:0] acc_q;

	logic [W:0]   sum_acc;
	logic [W:0]   sum_dbl;
	logic [W:0]   m_ext;
	logic [W-1:0] acc_nxt;
	logic [W-1:0] dbl_nxt;

	// both operands stay below m, so one conditional subtract suffices
	always_comb begin
		m_ext   = {1'b0, m};
		sum_acc = {1'b0, acc_q} + {1'b0, y_q};
		sum_dbl = {1'b0, y_q} + {1'b0, y_q};
		acc_nxt = (sum_acc >= m_ext) ? W'(sum_acc - m_ext) : W'(sum_acc);
		dbl_nxt = (sum_dbl >= m_ext) ? W'(sum_dbl - m_ext) : W'(sum_dbl);
	end

	assign done    = run_q && (x_q == '0);
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (run_q && (x_q != '0)) begin
			if (x_q[0]) begin
				acc_q <= acc_nxt;
			end
			x_q <= x_q >> 1;
			y_q <= dbl_nxt;
		end
	end

endmodule

`default_nettype wire
